// File: sv/lfs_pkg.sv
// Package for the line-follow steering unit: shared types, register indexes,
// reset values and steering constants. No dependencies.
package lfs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 10;
    localparam int DRIVE_LIMIT_DEF  = 255;
    localparam int NUM_SENSORS      = 5;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int SPEED_WIDTH      = 8;
    localparam int MAG_WIDTH        = 8;
    localparam int TURN_WIDTH       = 3;
    // Internal positive drive width: holds the largest speed plus offset.
    localparam int DRIVE_WIDTH      = 10;

    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index CFG_THRESHOLD_S0 = 3'd0;
    localparam t_cfg_index CFG_THRESHOLD_S1 = 3'd1;
    localparam t_cfg_index CFG_THRESHOLD_S2 = 3'd2;
    localparam t_cfg_index CFG_THRESHOLD_S3 = 3'd3;
    localparam t_cfg_index CFG_THRESHOLD_S4 = 3'd4;
    localparam t_cfg_index CFG_CRUISE_SPEED = 3'd5;

    localparam int THRESHOLD_S0_RESET = 310;
    localparam int THRESHOLD_S1_RESET = 270;
    localparam int THRESHOLD_S2_RESET = 280;
    localparam int THRESHOLD_S3_RESET = 310;
    localparam int THRESHOLD_S4_RESET = 240;
    localparam logic [SPEED_WIDTH-1:0] CRUISE_SPEED_RESET = 8'd130;

    localparam logic [DRIVE_WIDTH-1:0] GENTLE_BOOST = 10'd20;
    localparam logic [DRIVE_WIDTH-1:0] HARD_BOOST   = 10'd30;
    localparam logic [DRIVE_WIDTH-1:0] PIVOT_BACK   = 10'd50;
    localparam logic [DRIVE_WIDTH-1:0] SEARCH_BACK  = 10'd60;

    typedef logic signed [TURN_WIDTH-1:0] t_turn;

    localparam t_turn TURN_HARD_LEFT   = -3'sd2;
    localparam t_turn TURN_LEFT        = -3'sd1;
    localparam t_turn TURN_STRAIGHT    = 3'sd0;
    localparam t_turn TURN_RIGHT       = 3'sd1;
    localparam t_turn TURN_HARD_RIGHT  = 3'sd2;

    typedef struct packed {
        logic [MAG_WIDTH-1:0] mag;
        logic                 rev;
    } t_drive;

endpackage

// File: sv/lfs_sample_if.sv
// Input channel of the line-follow steering unit: one word of five sensor
// samples and the run flag. Depends on nothing but its width parameter.
interface lfs_sample_if #(
    parameter int SAMPLE_WIDTH = 10
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_s0;
    logic [SAMPLE_WIDTH-1:0] sample_s1;
    logic [SAMPLE_WIDTH-1:0] sample_s2;
    logic [SAMPLE_WIDTH-1:0] sample_s3;
    logic [SAMPLE_WIDTH-1:0] sample_s4;
    logic                    run_enable;

    modport source (
        output valid, sample_s0, sample_s1, sample_s2, sample_s3, sample_s4, run_enable,
        input  ready
    );
    modport sink (
        input  valid, sample_s0, sample_s1, sample_s2, sample_s3, sample_s4, run_enable,
        output ready
    );
endinterface

// File: sv/lfs_drive_if.sv
// Output channel of the line-follow steering unit: one word of wheel drives,
// line bits and heading memory. Field widths are fixed.
interface lfs_drive_if;
    logic              valid;
    logic              ready;
    logic [7:0]        left_magnitude;
    logic              left_reverse;
    logic [7:0]        right_magnitude;
    logic              right_reverse;
    logic [4:0]        line_bits;
    logic signed [2:0] heading_memory;

    modport source (
        output valid, left_magnitude, left_reverse, right_magnitude, right_reverse,
               line_bits, heading_memory,
        input  ready
    );
    modport sink (
        input  valid, left_magnitude, left_reverse, right_magnitude, right_reverse,
               line_bits, heading_memory,
        output ready
    );
endinterface

// File: sv/lfs_sense.sv
// Threshold stage: compares each sensor sample with its own threshold.
// Depends on lfs_pkg.
module lfs_sense #(
    parameter int SAMPLE_WIDTH    = lfs_pkg::SAMPLE_WIDTH_DEF,
    parameter int THRESHOLD_WIDTH = 10
) (
    input  logic [lfs_pkg::NUM_SENSORS-1:0][SAMPLE_WIDTH-1:0]    i_samples,
    input  logic [lfs_pkg::NUM_SENSORS-1:0][THRESHOLD_WIDTH-1:0] i_thresholds,
    output logic [lfs_pkg::NUM_SENSORS-1:0]                      o_line_bits
);

    always_comb begin
        for (int i = 0; i < lfs_pkg::NUM_SENSORS; i++) begin
            o_line_bits[i] = THRESHOLD_WIDTH'(i_samples[i]) >= i_thresholds[i];
        end
    end

endmodule

// File: sv/lfs_steer.sv
// Steering rule: maps line bits, cruise speed and the remembered turn to
// saturated wheel drives and the next turn memory. Depends on lfs_pkg.
module lfs_steer #(
    parameter int DRIVE_LIMIT = lfs_pkg::DRIVE_LIMIT_DEF
) (
    input  logic [lfs_pkg::NUM_SENSORS-1:0] i_line_bits,
    input  logic                            i_run,
    input  logic [lfs_pkg::SPEED_WIDTH-1:0] i_cruise,
    input  lfs_pkg::t_turn                  i_last_turn,
    output lfs_pkg::t_turn                  o_next_turn,
    output lfs_pkg::t_drive                 o_left,
    output lfs_pkg::t_drive                 o_right
);

    localparam logic [lfs_pkg::DRIVE_WIDTH-1:0] LIMIT = lfs_pkg::DRIVE_WIDTH'(DRIVE_LIMIT);

    logic [lfs_pkg::DRIVE_WIDTH-1:0] c_full;
    logic [lfs_pkg::DRIVE_WIDTH-1:0] c_half;
    logic [lfs_pkg::DRIVE_WIDTH-1:0] c_gentle;
    logic [lfs_pkg::DRIVE_WIDTH-1:0] c_hard;
    logic [lfs_pkg::DRIVE_WIDTH-1:0] l_mag;
    logic [lfs_pkg::DRIVE_WIDTH-1:0] r_mag_raw;
    logic                            l_neg;
    logic                            r_neg;

    function automatic lfs_pkg::t_drive make_drive(
        input logic [lfs_pkg::DRIVE_WIDTH-1:0] mag,
        input logic                            neg
    );
        lfs_pkg::t_drive d;
        logic [lfs_pkg::DRIVE_WIDTH-1:0] sat;
        // Backward drives are small constants, well inside the limit.
        sat = (!neg && (mag > LIMIT)) ? LIMIT : mag;
        d.mag = sat[lfs_pkg::MAG_WIDTH-1:0];
        d.rev = neg;
        return d;
    endfunction

    assign c_full   = lfs_pkg::DRIVE_WIDTH'(i_cruise);
    assign c_half   = lfs_pkg::DRIVE_WIDTH'(i_cruise >> 1);
    assign c_gentle = c_full + lfs_pkg::GENTLE_BOOST;
    assign c_hard   = c_full + lfs_pkg::HARD_BOOST;

    always_comb begin
        o_next_turn = i_last_turn;
        l_mag       = '0;
        r_mag_raw   = '0;
        l_neg       = 1'b0;
        r_neg       = 1'b0;
        if (i_run) begin
            if (i_line_bits[2] && !i_line_bits[1] && !i_line_bits[3]) begin
                l_mag = c_full;
                r_mag_raw = c_full;
                o_next_turn = lfs_pkg::TURN_STRAIGHT;
            end else if (i_line_bits[1] && !i_line_bits[0]) begin
                l_mag = c_half;
                r_mag_raw = c_gentle;
                o_next_turn = lfs_pkg::TURN_LEFT;
            end else if (i_line_bits[0]) begin
                l_mag = lfs_pkg::PIVOT_BACK;
                l_neg = 1'b1;
                r_mag_raw = c_hard;
                o_next_turn = lfs_pkg::TURN_HARD_LEFT;
            end else if (i_line_bits[3] && !i_line_bits[4]) begin
                l_mag = c_gentle;
                r_mag_raw = c_half;
                o_next_turn = lfs_pkg::TURN_RIGHT;
            end else if (i_line_bits[4]) begin
                l_mag = c_hard;
                r_mag_raw = lfs_pkg::PIVOT_BACK;
                r_neg = 1'b1;
                o_next_turn = lfs_pkg::TURN_HARD_RIGHT;
            end else if (i_last_turn < lfs_pkg::TURN_STRAIGHT) begin
                // Line lost: search toward the side it was last seen on.
                l_mag = lfs_pkg::SEARCH_BACK;
                l_neg = 1'b1;
                r_mag_raw = c_full;
            end else if (i_last_turn > lfs_pkg::TURN_STRAIGHT) begin
                l_mag = c_full;
                r_mag_raw = lfs_pkg::SEARCH_BACK;
                r_neg = 1'b1;
            end else begin
                l_mag = c_full;
                r_mag_raw = c_full;
            end
        end
    end

    assign o_left  = make_drive(l_mag, l_neg);
    assign o_right = make_drive(r_mag_raw, r_neg);

endmodule

// File: sv/line_follow_steering_unit.sv
// Line-follow steering unit, top level. Depends on lfs_pkg, lfs_sample_if,
// lfs_drive_if, lfs_sense and lfs_steer.
// Path: a word accepted into the input register is steered and held in the output register, which offers it.
// Throughput: one word per cycle; a stalled result holds off the input only once
// the input register holds a word as well.
// Reset: valid flags clear, configuration registers take their defaults, turn memory straight ahead.
module line_follow_steering_unit #(
    parameter int SAMPLE_WIDTH = lfs_pkg::SAMPLE_WIDTH_DEF,
    parameter int DRIVE_LIMIT  = lfs_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    lfs_sample_if.sink              i_sens,
    lfs_drive_if.source             o_drive,
    input  logic                    i_cfg_we,
    input  lfs_pkg::t_cfg_index     i_cfg_index,
    input  logic [SAMPLE_WIDTH-1:0] i_cfg_data
);

    // Thresholds are wide enough to hold their reset values at any sample width.
    localparam int THRESHOLD_WIDTH = (SAMPLE_WIDTH > 10) ? SAMPLE_WIDTH : 10;
    localparam int NS = lfs_pkg::NUM_SENSORS;

    logic [NS-1:0][THRESHOLD_WIDTH-1:0] r_thresholds;
    logic [lfs_pkg::SPEED_WIDTH-1:0]    r_cruise;
    lfs_pkg::t_turn                     r_last_turn;

    logic                               r_s1_valid;
    logic [NS-1:0][SAMPLE_WIDTH-1:0]    r_s1_samples;
    logic                               r_s1_run;

    logic                               r_out_valid;
    lfs_pkg::t_drive                    r_out_left;
    lfs_pkg::t_drive                    r_out_right;
    logic [NS-1:0]                      r_out_bits;
    lfs_pkg::t_turn                     r_out_turn;

    logic                               out_load;
    logic                               in_accept;
    logic [NS-1:0]                      line_bits;
    lfs_pkg::t_turn                     n_last_turn;
    lfs_pkg::t_drive                    left_drive;
    lfs_pkg::t_drive                    right_drive;

    assign out_load     = r_s1_valid && (!r_out_valid || o_drive.ready);
    assign i_sens.ready = !r_s1_valid || out_load;
    assign in_accept    = i_sens.valid && i_sens.ready;

    lfs_sense #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .THRESHOLD_WIDTH (THRESHOLD_WIDTH)
    ) u_sense (
        .i_samples    (r_s1_samples),
        .i_thresholds (r_thresholds),
        .o_line_bits  (line_bits)
    );

    lfs_steer #(
        .DRIVE_LIMIT (DRIVE_LIMIT)
    ) u_steer (
        .i_line_bits (line_bits),
        .i_run       (r_s1_run),
        .i_cruise    (r_cruise),
        .i_last_turn (r_last_turn),
        .o_next_turn (n_last_turn),
        .o_left      (left_drive),
        .o_right     (right_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresholds[0] <= THRESHOLD_WIDTH'(lfs_pkg::THRESHOLD_S0_RESET);
            r_thresholds[1] <= THRESHOLD_WIDTH'(lfs_pkg::THRESHOLD_S1_RESET);
            r_thresholds[2] <= THRESHOLD_WIDTH'(lfs_pkg::THRESHOLD_S2_RESET);
            r_thresholds[3] <= THRESHOLD_WIDTH'(lfs_pkg::THRESHOLD_S3_RESET);
            r_thresholds[4] <= THRESHOLD_WIDTH'(lfs_pkg::THRESHOLD_S4_RESET);
            r_cruise        <= lfs_pkg::CRUISE_SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfs_pkg::CFG_THRESHOLD_S0: r_thresholds[0] <= THRESHOLD_WIDTH'(i_cfg_data);
                lfs_pkg::CFG_THRESHOLD_S1: r_thresholds[1] <= THRESHOLD_WIDTH'(i_cfg_data);
                lfs_pkg::CFG_THRESHOLD_S2: r_thresholds[2] <= THRESHOLD_WIDTH'(i_cfg_data);
                lfs_pkg::CFG_THRESHOLD_S3: r_thresholds[3] <= THRESHOLD_WIDTH'(i_cfg_data);
                lfs_pkg::CFG_THRESHOLD_S4: r_thresholds[4] <= THRESHOLD_WIDTH'(i_cfg_data);
                lfs_pkg::CFG_CRUISE_SPEED: r_cruise <= i_cfg_data[lfs_pkg::SPEED_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_turn <= lfs_pkg::TURN_STRAIGHT;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_last_turn <= n_last_turn;
            end else if (o_drive.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_samples[0] <= i_sens.sample_s0;
            r_s1_samples[1] <= i_sens.sample_s1;
            r_s1_samples[2] <= i_sens.sample_s2;
            r_s1_samples[3] <= i_sens.sample_s3;
            r_s1_samples[4] <= i_sens.sample_s4;
            r_s1_run        <= i_sens.run_enable;
        end
        if (out_load) begin
            r_out_left  <= left_drive;
            r_out_right <= right_drive;
            r_out_bits  <= line_bits;
            r_out_turn  <= n_last_turn;
        end
    end

    assign o_drive.valid           = r_out_valid;
    assign o_drive.left_magnitude  = r_out_left.mag;
    assign o_drive.left_reverse    = r_out_left.rev;
    assign o_drive.right_magnitude = r_out_right.mag;
    assign o_drive.right_reverse   = r_out_right.rev;
    assign o_drive.line_bits       = r_out_bits;
    assign o_drive.heading_memory  = r_out_turn;

endmodule

// File: tb/tb_line_follow_steering_unit.sv
// Self-checking testbench for the line-follow steering unit: directed and random
// sample words against a cycle-free predictor. Depends on lfs_pkg, lfs_sample_if,
// lfs_drive_if and line_follow_steering_unit.
module tb_line_follow_steering_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = lfs_pkg::SAMPLE_WIDTH_DEF;
    localparam int NSNS        = lfs_pkg::NUM_SENSORS;
    localparam int SAMPLE_MAX  = (1 << SW) - 1;
    localparam int DRV_LIMIT   = lfs_pkg::DRIVE_LIMIT_DEF;
    localparam int GENTLE      = int'(lfs_pkg::GENTLE_BOOST);
    localparam int HARD        = int'(lfs_pkg::HARD_BOOST);
    localparam int PIVOT       = int'(lfs_pkg::PIVOT_BACK);
    localparam int SEARCH      = int'(lfs_pkg::SEARCH_BACK);
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE      = 4;

    // Indexes beyond the register map; writes to them must be ignored.
    localparam lfs_pkg::t_cfg_index CFG_SPARE_A = 3'd6;
    localparam lfs_pkg::t_cfg_index CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                    run;
        logic [NSNS-1:0][SW-1:0] smp;
    } t_sensor_word;

    typedef struct packed {
        lfs_pkg::t_drive left;
        lfs_pkg::t_drive right;
        logic [NSNS-1:0] line_bits;
        lfs_pkg::t_turn  heading;
    } t_steer_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    lfs_pkg::t_cfg_index cfg_index;
    logic [SW-1:0]       cfg_data;

    lfs_sample_if #(.SAMPLE_WIDTH(SW)) sens_if ();
    lfs_drive_if                       drive_if ();

    line_follow_steering_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sens      (sens_if),
        .o_drive     (drive_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow of the block's registers and turn memory.
    logic [SW-1:0]                   thr_q [NSNS];
    logic [lfs_pkg::SPEED_WIDTH-1:0] cruise_q;
    lfs_pkg::t_turn                  heading_q;

    t_steer_word pending_drive_q [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic lfs_pkg::t_drive to_drive(int v);
        lfs_pkg::t_drive d;
        int              m;
        if (v > DRV_LIMIT) v = DRV_LIMIT;
        if (v < -DRV_LIMIT) v = -DRV_LIMIT;
        d.rev = (v < 0);
        m = (v < 0) ? -v : v;
        d.mag = m[lfs_pkg::MAG_WIDTH-1:0];
        return d;
    endfunction

    // Works out the result word for one accepted sample word and advances the
    // turn memory exactly as the block should.
    function automatic t_steer_word steer_predict(t_sensor_word w);
        t_steer_word     res;
        logic [NSNS-1:0] b;
        int              c;
        int              l;
        int              r;
        for (int i = 0; i < NSNS; i++) b[i] = (w.smp[i] >= thr_q[i]);
        c = int'(cruise_q);
        l = 0;
        r = 0;
        if (w.run) begin
            if (b[2] && !b[1] && !b[3]) begin
                l = c;          r = c;          heading_q = lfs_pkg::TURN_STRAIGHT;
            end else if (b[1] && !b[0]) begin
                l = c >> 1;     r = c + GENTLE; heading_q = lfs_pkg::TURN_LEFT;
            end else if (b[0]) begin
                l = -PIVOT;     r = c + HARD;   heading_q = lfs_pkg::TURN_HARD_LEFT;
            end else if (b[3] && !b[4]) begin
                l = c + GENTLE; r = c >> 1;     heading_q = lfs_pkg::TURN_RIGHT;
            end else if (b[4]) begin
                l = c + HARD;   r = -PIVOT;     heading_q = lfs_pkg::TURN_HARD_RIGHT;
            end else if (heading_q < lfs_pkg::TURN_STRAIGHT) begin
                l = -SEARCH;    r = c;
            end else if (heading_q > lfs_pkg::TURN_STRAIGHT) begin
                l = c;          r = -SEARCH;
            end else begin
                l = c;          r = c;
            end
        end
        res.left      = to_drive(l);
        res.right     = to_drive(r);
        res.line_bits = b;
        res.heading   = heading_q;
        return res;
    endfunction

    // Puts samples on the wanted side of each threshold; none below a zero one.
    function automatic t_sensor_word make_word(logic [NSNS-1:0] pat, logic run);
        t_sensor_word w;
        int           t;
        for (int i = 0; i < NSNS; i++) begin
            t = int'(thr_q[i]);
            if (pat[i] || t == 0) w.smp[i] = SW'($urandom_range(SAMPLE_MAX, t));
            else                  w.smp[i] = SW'($urandom_range(t - 1, 0));
        end
        w.run = run;
        return w;
    endfunction

    function automatic t_sensor_word flat_word(int value, logic run);
        t_sensor_word w;
        for (int i = 0; i < NSNS; i++) w.smp[i] = SW'(value);
        w.run = run;
        return w;
    endfunction

    task automatic send_word(t_sensor_word w);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(11, 1)) begin
                @(negedge i_clk);
                sens_if.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        sens_if.valid      <= 1'b1;
        sens_if.sample_s0  <= w.smp[0];
        sens_if.sample_s1  <= w.smp[1];
        sens_if.sample_s2  <= w.smp[2];
        sens_if.sample_s3  <= w.smp[3];
        sens_if.sample_s4  <= w.smp[4];
        sens_if.run_enable <= w.run;
        do @(posedge i_clk); while (!sens_if.ready);
        pending_drive_q.push_back(steer_predict(w));
    endtask

    task automatic send_pattern(logic [NSNS-1:0] pat, logic run);
        send_word(make_word(pat, run));
    endtask

    // Stops offering words and waits until every expected result has come.
    task automatic drain();
        @(negedge i_clk);
        sens_if.valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(lfs_pkg::t_cfg_index idx, logic [SW-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx < NSNS)                            thr_q[idx] = data;
        else if (idx == lfs_pkg::CFG_CRUISE_SPEED) cruise_q = data[lfs_pkg::SPEED_WIDTH-1:0];
    endtask

    task automatic write_thresholds(int value);
        write_reg(lfs_pkg::CFG_THRESHOLD_S0, SW'(value));
        write_reg(lfs_pkg::CFG_THRESHOLD_S1, SW'(value));
        write_reg(lfs_pkg::CFG_THRESHOLD_S2, SW'(value));
        write_reg(lfs_pkg::CFG_THRESHOLD_S3, SW'(value));
        write_reg(lfs_pkg::CFG_THRESHOLD_S4, SW'(value));
    endtask

    task automatic test_rule_table();
        send_pattern(5'b00100, 1'b1);
        send_pattern(5'b00000, 1'b1);
        send_pattern(5'b00010, 1'b1);
        send_pattern(5'b00000, 1'b1);
        send_pattern(5'b00001, 1'b1);
        send_pattern(5'b01000, 1'b1);
        send_pattern(5'b00000, 1'b1);
        send_pattern(5'b10000, 1'b1);
        // Stopped: zero drive, line still reported, turn memory untouched.
        send_pattern(5'b00010, 1'b0);
        send_pattern(5'b00000, 1'b1);
        send_pattern(5'b00110, 1'b1);
        send_pattern(5'b11111, 1'b1);
    endtask

    task automatic test_sample_extremes();
        t_sensor_word w;
        send_word(flat_word(0, 1'b1));
        send_word(flat_word(SAMPLE_MAX, 1'b1));
        for (int i = 0; i < NSNS; i++) w.smp[i] = thr_q[i];
        w.run = 1'b1;
        send_word(w);
        for (int i = 0; i < NSNS; i++) w.smp[i] = thr_q[i] - 1'b1;
        send_word(w);
    endtask

    task automatic test_cruise_extremes();
        drain();
        // Upper data bits must be dropped, leaving full speed.
        write_reg(lfs_pkg::CFG_CRUISE_SPEED, SW'(SAMPLE_MAX));
        send_pattern(5'b00010, 1'b1);
        send_pattern(5'b00001, 1'b1);
        send_pattern(5'b01000, 1'b1);
        send_pattern(5'b10000, 1'b1);
        drain();
        write_reg(lfs_pkg::CFG_CRUISE_SPEED, '0);
        send_pattern(5'b00100, 1'b1);
        send_pattern(5'b10000, 1'b1);
        send_pattern(5'b00000, 1'b1);
        drain();
        write_reg(lfs_pkg::CFG_CRUISE_SPEED, SW'(131));
        send_pattern(5'b01000, 1'b1);
    endtask

    task automatic test_threshold_extremes();
        drain();
        write_thresholds(0);
        write_reg(CFG_SPARE_A, SW'($urandom_range(SAMPLE_MAX, 0)));
        send_word(flat_word(0, 1'b1));
        drain();
        write_thresholds(SAMPLE_MAX);
        write_reg(CFG_SPARE_B, SW'(SAMPLE_MAX));
        send_word(flat_word(SAMPLE_MAX - 1, 1'b1));
        send_word(flat_word(SAMPLE_MAX, 1'b1));
    endtask

    function automatic logic [NSNS-1:0] track_pattern();
        logic [NSNS-1:0] shapes [10] = '{5'b00100, 5'b00110, 5'b00010, 5'b00011,
            5'b00001, 5'b01100, 5'b01000, 5'b11000, 5'b10000, 5'b01110};
        return shapes[$urandom_range(9, 0)];
    endfunction

    task automatic send_random_word();
        t_sensor_word w;
        logic         run;
        run = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w = make_word(track_pattern(), run);
            6, 7: w = make_word(NSNS'($urandom), run);
            8: begin
                for (int i = 0; i < NSNS; i++) w.smp[i] = SW'($urandom);
                w.run = run;
            end
            default: w = make_word('0, run);
        endcase
        send_word(w);
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the block fills up and must stall its input.
    task automatic test_backpressure();
        drain();
        hold_cycles = 300;
        repeat (30) send_random_word();
        drain();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            drain();
            write_reg(lfs_pkg::CFG_THRESHOLD_S0, SW'($urandom_range(900, 100)));
            write_reg(lfs_pkg::CFG_THRESHOLD_S1, SW'($urandom_range(900, 100)));
            write_reg(lfs_pkg::CFG_THRESHOLD_S2, SW'($urandom_range(900, 100)));
            write_reg(lfs_pkg::CFG_THRESHOLD_S3, SW'($urandom_range(900, 100)));
            write_reg(lfs_pkg::CFG_THRESHOLD_S4, SW'($urandom_range(SAMPLE_MAX, 0)));
            write_reg(lfs_pkg::CFG_CRUISE_SPEED, SW'($urandom_range(SAMPLE_MAX, 0)));
            if ($urandom_range(0, 1)) write_reg(CFG_SPARE_A, SW'($urandom));
            if (p == phases - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            repeat (per_phase) send_random_word();
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left     = 0;
        drive_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                drive_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                drive_if.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(10, 0);
                drive_if.ready <= 1'b0;
            end else begin
                drive_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_steer_word e;
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            if (pending_drive_q.size() == 0) begin
                $error("result word with no expectation waiting");
                error_count++;
            end else begin
                e = pending_drive_q.pop_front();
                if (drive_if.left_magnitude !== e.left.mag) begin
                    $error("left_magnitude: expected %0d, got %0d",
                           e.left.mag, drive_if.left_magnitude);
                    error_count++;
                end
                if (drive_if.left_reverse !== e.left.rev) begin
                    $error("left_reverse: expected %0b, got %0b",
                           e.left.rev, drive_if.left_reverse);
                    error_count++;
                end
                if (drive_if.right_magnitude !== e.right.mag) begin
                    $error("right_magnitude: expected %0d, got %0d",
                           e.right.mag, drive_if.right_magnitude);
                    error_count++;
                end
                if (drive_if.right_reverse !== e.right.rev) begin
                    $error("right_reverse: expected %0b, got %0b",
                           e.right.rev, drive_if.right_reverse);
                    error_count++;
                end
                if (drive_if.line_bits !== e.line_bits) begin
                    $error("line_bits: expected %b, got %b",
                           e.line_bits, drive_if.line_bits);
                    error_count++;
                end
                if (drive_if.heading_memory !== e.heading) begin
                    $error("heading_memory: expected %0d, got %0d",
                           e.heading, drive_if.heading_memory);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = lfs_pkg::CFG_THRESHOLD_S0;
        cfg_data           = '0;
        sens_if.valid      = 1'b0;
        sens_if.sample_s0  = '0;
        sens_if.sample_s1  = '0;
        sens_if.sample_s2  = '0;
        sens_if.sample_s3  = '0;
        sens_if.sample_s4  = '0;
        sens_if.run_enable = 1'b0;
        tx_idle_en         = 1'b1;
        rx_idle_en         = 1'b1;
        thr_q[0]  = SW'(lfs_pkg::THRESHOLD_S0_RESET);
        thr_q[1]  = SW'(lfs_pkg::THRESHOLD_S1_RESET);
        thr_q[2]  = SW'(lfs_pkg::THRESHOLD_S2_RESET);
        thr_q[3]  = SW'(lfs_pkg::THRESHOLD_S3_RESET);
        thr_q[4]  = SW'(lfs_pkg::THRESHOLD_S4_RESET);
        cruise_q  = lfs_pkg::CRUISE_SPEED_RESET;
        heading_q = lfs_pkg::TURN_STRAIGHT;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_rule_table();
        test_sample_extremes();
        test_cruise_extremes();
        test_threshold_extremes();
        test_backpressure();
        test_random(4, 120);

        drain();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_drive_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
